@@ hdl/itoa_pkg.sv @@
// Shared types, constants and character helper for the integer to ASCII formatter.
package itoa_pkg;

  // format selector codes
  localparam logic [2:0] FMT_SDEC32 = 3'd0;
  localparam logic [2:0] FMT_UDEC32 = 3'd1;
  localparam logic [2:0] FMT_HEXL32 = 3'd2;
  localparam logic [2:0] FMT_HEXU32 = 3'd3;
  localparam logic [2:0] FMT_HEXL64 = 3'd4;

  localparam int CMD_W      = 3;
  localparam int VAL_W      = 64;
  localparam int BIN_W      = 32;               // decimal formats work on 32 bits
  localparam int BCD_DIGITS = 10;               // enough for 4294967295
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int SH_W       = BCD_W + BIN_W;
  localparam int CNT_W      = $clog2(BIN_W);
  localparam int NDIG       = VAL_W / 4;        // nibble slots in the digit register
  localparam int NDIG_W     = $clog2(NDIG) + 1;
  localparam int CHAR_W     = 7;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWA  = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_UPA   = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_STRIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic dd_step;
    logic strip;
    logic emit_shift;
    logic sel_sign;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic acc_bad;    // selector on the input port is unused
    logic acc_dec;    // selector on the input port is a decimal format
    logic dd_last;    // final shift-add step
    logic top_nz;     // leading nibble is non-zero
    logic ndig_one;   // one digit left
    logic neg;        // minus sign to be sent
  } dp_status_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [CHAR_W-1:0] n7;
    n7 = {3'b000, nib};
    if (nib < 4'd10) begin
      hex_char = CHAR_ZERO + n7;
    end else if (upper) begin
      hex_char = CHAR_UPA + n7 - 7'd10;
    end else begin
      hex_char = CHAR_LOWA + n7 - 7'd10;
    end
  endfunction

endpackage

@@ hdl/itoa_ctrl.sv @@
// Sequencing state machine for the integer to ASCII formatter.
module itoa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  itoa_pkg::dp_status_t sts,
  output itoa_pkg::ctrl_cmd_t  cmd
);

  itoa_pkg::state_t state_r, state_nxt;
  logic strip_done;

  assign strip_done = sts.top_nz || sts.ndig_one;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itoa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      itoa_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (sts.acc_bad) begin
            state_nxt = itoa_pkg::ST_IDLE;
          end else if (sts.acc_dec) begin
            state_nxt = itoa_pkg::ST_CONV;
          end else begin
            state_nxt = itoa_pkg::ST_STRIP;
          end
        end
      end
      itoa_pkg::ST_CONV: begin
        if (sts.dd_last) begin
          state_nxt = itoa_pkg::ST_STRIP;
        end
      end
      itoa_pkg::ST_STRIP: begin
        if (strip_done) begin
          state_nxt = sts.neg ? itoa_pkg::ST_SIGN : itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_SIGN: begin
        if (out_tready) begin
          state_nxt = itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_EMIT: begin
        if (out_tready && sts.ndig_one) begin
          state_nxt = itoa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = itoa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready      = 1'b0;
    out_tvalid     = 1'b0;
    cmd            = '0;
    case (state_r)
      itoa_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      itoa_pkg::ST_CONV: begin
        cmd.dd_step = 1'b1;
      end
      itoa_pkg::ST_STRIP: begin
        cmd.strip = !strip_done;
      end
      itoa_pkg::ST_SIGN: begin
        out_tvalid   = 1'b1;
        cmd.sel_sign = 1'b1;
      end
      itoa_pkg::ST_EMIT: begin
        out_tvalid     = 1'b1;
        cmd.emit_shift = out_tready;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

@@ hdl/itoa_dp.sv @@
// Datapath: shift-add binary to BCD, digit register, leading zero strip, character map.
module itoa_dp (
  input  logic                                clk,
  input  logic [itoa_pkg::CMD_W-1:0]          in_cmd,
  input  logic [itoa_pkg::VAL_W-1:0]          in_value,
  input  itoa_pkg::ctrl_cmd_t                 cmd,
  output itoa_pkg::dp_status_t                sts,
  output logic [itoa_pkg::CHAR_W-1:0]         char_code,
  output logic                                last_char
);

  logic [itoa_pkg::SH_W-1:0]   sh_r, sh_nxt, sh_adj;
  logic [itoa_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [itoa_pkg::VAL_W-1:0]  dig_r, dig_nxt;
  logic [itoa_pkg::NDIG_W-1:0] ndig_r, ndig_nxt;
  logic                        neg_r, neg_nxt;
  logic                        upper_r, upper_nxt;
  logic [itoa_pkg::BIN_W-1:0]  lo, mag;
  logic                        in_neg, dd_last;

  assign lo      = in_value[itoa_pkg::BIN_W-1:0];
  assign in_neg  = (in_cmd == itoa_pkg::FMT_SDEC32) && lo[itoa_pkg::BIN_W-1];
  assign mag     = in_neg ? (~lo + 1'b1) : lo;
  assign dd_last = (cnt_r == itoa_pkg::CNT_W'(itoa_pkg::BIN_W - 1));

  // add 3 to every BCD digit of 5 or more, then shift in the next binary bit
  always_comb begin
    sh_adj = sh_r;
    for (int d = 0; d < itoa_pkg::BCD_DIGITS; d++) begin
      if (sh_r[itoa_pkg::BIN_W + 4*d +: 4] >= 4'd5) begin
        sh_adj[itoa_pkg::BIN_W + 4*d +: 4] = sh_r[itoa_pkg::BIN_W + 4*d +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    sh_nxt    = sh_r;
    cnt_nxt   = cnt_r;
    dig_nxt   = dig_r;
    ndig_nxt  = ndig_r;
    neg_nxt   = neg_r;
    upper_nxt = upper_r;
    if (cmd.load) begin
      neg_nxt   = in_neg;
      upper_nxt = (in_cmd == itoa_pkg::FMT_HEXU32);
      sh_nxt    = {{itoa_pkg::BCD_W{1'b0}}, mag};
      cnt_nxt   = '0;
      ndig_nxt  = itoa_pkg::NDIG_W'(itoa_pkg::NDIG);
      if (in_cmd == itoa_pkg::FMT_HEXL64) begin
        dig_nxt = in_value;
      end else begin
        dig_nxt = {{(itoa_pkg::VAL_W - itoa_pkg::BIN_W){1'b0}}, lo};
      end
    end else if (cmd.dd_step) begin
      sh_nxt  = {sh_adj[itoa_pkg::SH_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (dd_last) begin
        dig_nxt = {{(itoa_pkg::VAL_W - itoa_pkg::BCD_W){1'b0}},
                   sh_nxt[itoa_pkg::SH_W-1:itoa_pkg::BIN_W]};
      end
    end else if (cmd.strip || cmd.emit_shift) begin
      dig_nxt  = {dig_r[itoa_pkg::VAL_W-5:0], 4'h0};
      ndig_nxt = ndig_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    sh_r    <= sh_nxt;
    cnt_r   <= cnt_nxt;
    dig_r   <= dig_nxt;
    ndig_r  <= ndig_nxt;
    neg_r   <= neg_nxt;
    upper_r <= upper_nxt;
  end

  assign sts.acc_bad  = (in_cmd > itoa_pkg::FMT_HEXL64);
  assign sts.acc_dec  = (in_cmd == itoa_pkg::FMT_SDEC32) || (in_cmd == itoa_pkg::FMT_UDEC32);
  assign sts.dd_last  = dd_last;
  assign sts.top_nz   = (dig_r[itoa_pkg::VAL_W-1 -: 4] != 4'h0);
  assign sts.ndig_one = (ndig_r == itoa_pkg::NDIG_W'(1));
  assign sts.neg      = neg_r;

  assign char_code = cmd.sel_sign ? itoa_pkg::CHAR_MINUS
                                  : itoa_pkg::hex_char(dig_r[itoa_pkg::VAL_W-1 -: 4], upper_r);
  assign last_char = !cmd.sel_sign && (ndig_r == itoa_pkg::NDIG_W'(1));

endmodule

@@ hdl/integer_to_ascii_formatter.sv @@
// Top level of the integer to ASCII formatter.
//
// Usage: one number enters on the in_ channel (value in in_tdata, format in in_tuser)
// and leaves as ASCII text on the out_ channel, one character per item, most
// significant digit first, no leading zeros; out_tlast marks the final character.
// Formats: 0 signed dec32, 1 unsigned dec32, 2 hex lower32, 3 hex upper32,
// 4 hex lower64. Selectors 5 to 7 are taken and give no output.
// One number is worked on at a time; in_tready is high only while idle.
// Decimal formats first pass through the shift-add BCD converter, then drop up
// to 15 leading zero nibbles, one nibble a cycle, and then find the leading
// digit; hex formats go straight to the zero strip. Characters then follow one
// per cycle while out_tready is high, a minus sign first where one is due.
// A stall on out_tready holds the current character and its tlast steady.
// Reset returns the controller to idle; any text in progress is dropped.
module integer_to_ascii_formatter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] value
  input  logic [2:0]  in_tuser,   // [2:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [6:0] char_code, [7] zero
  output logic        out_tlast   // last_char
);

  itoa_pkg::ctrl_cmd_t               cmd;
  itoa_pkg::dp_status_t              sts;
  logic [itoa_pkg::CHAR_W-1:0]       char_code;

  itoa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  itoa_dp u_dp (
    .clk       (clk),
    .in_cmd    (in_tuser),
    .in_value  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .char_code (char_code),
    .last_char (out_tlast)
  );

  assign out_tdata = {1'b0, char_code};

endmodule

@@ hdl/itoa_chk.sv @@
// Port-level checks for the integer to ASCII formatter, bound to the top level.
module itoa_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast
);

  // a character waiting on the receiver stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed while stalled");

  // one number at a time: no new item is taken while text is being sent
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while output active");

  // text never starts in the cycle right after an item is taken
  a_no_instant_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid)
    else $error("output appeared straight after accept");

  // a minus sign is always followed by digits
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[6:0] == itoa_pkg::CHAR_MINUS) |-> !out_tlast)
    else $error("minus sign flagged as last");

  // characters are 7-bit ASCII
  a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[7])
    else $error("bit 7 of output set");

endmodule

bind integer_to_ascii_formatter itoa_chk u_itoa_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

@@ tb/tb_integer_to_ascii_formatter.sv @@
// Testbench for the integer to ASCII formatter: directed and random numbers, text checked per character.
`timescale 1ns / 1ps

module tb_integer_to_ascii_formatter;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 200;
  localparam int TAIL_CYCLES = 100;

  typedef struct packed {
    logic [itoa_pkg::CHAR_W-1:0] code;
    logic                        last;
  } text_char_t;

  // expected text of every accepted number, oldest character first
  class text_scoreboard;
    text_char_t text_q[$];
    int         errors;
    int         chars_checked;

    function new();
      errors        = 0;
      chars_checked = 0;
    endfunction

    function void note_number(logic [2:0] cmd, logic [itoa_pkg::VAL_W-1:0] value);
      logic [itoa_pkg::VAL_W-1:0]  mag;
      logic [itoa_pkg::BIN_W-1:0]  lo;
      logic [itoa_pkg::VAL_W-1:0]  radix;
      logic [3:0]                  dig;
      logic                        upper;
      logic                        neg;
      logic [itoa_pkg::CHAR_W-1:0] chars[$];
      text_char_t                  tc;
      lo    = value[itoa_pkg::BIN_W-1:0];
      upper = 1'b0;
      neg   = 1'b0;
      radix = 64'd16;
      case (cmd)
        itoa_pkg::FMT_SDEC32: begin
          neg   = lo[itoa_pkg::BIN_W-1];
          mag   = neg ? {32'd0, ~lo + 32'd1} : {32'd0, lo};
          radix = 64'd10;
        end
        itoa_pkg::FMT_UDEC32: begin
          mag   = {32'd0, lo};
          radix = 64'd10;
        end
        itoa_pkg::FMT_HEXL32: mag = {32'd0, lo};
        itoa_pkg::FMT_HEXU32: begin
          mag   = {32'd0, lo};
          upper = 1'b1;
        end
        itoa_pkg::FMT_HEXL64: mag = value;
        default: return;   // unused selector: no text
      endcase
      do begin
        dig = 4'(mag % radix);
        if (dig < 4'd10) begin
          chars.push_front(itoa_pkg::CHAR_ZERO + itoa_pkg::CHAR_W'(dig));
        end else begin
          chars.push_front((upper ? itoa_pkg::CHAR_UPA : itoa_pkg::CHAR_LOWA)
                           + itoa_pkg::CHAR_W'(dig) - 7'd10);
        end
        mag = mag / radix;
      end while (mag != 64'd0);
      if (neg) begin
        chars.push_front(itoa_pkg::CHAR_MINUS);
      end
      foreach (chars[i]) begin
        tc.code = chars[i];
        tc.last = (i == chars.size() - 1);
        text_q.push_back(tc);
      end
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_char(logic [7:0] data, logic last);
      text_char_t want;
      chars_checked++;
      if (text_q.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h last=%0b", data, last));
        return;
      end
      want = text_q.pop_front();
      if (data !== {1'b0, want.code}) begin
        report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h", data, want.code));
      end
      if (last !== want.last) begin
        report_mismatch($sformatf("last_char %0b, expected %0b (char 0x%02h)",
                                  last, want.last, want.code));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  text_scoreboard sb = new();

  logic idle_on;
  logic rx_hold_req;
  int   rx_stall;
  int   cycles;
  int   numbers_sent;
  int   ignored_sent;

  integer_to_ascii_formatter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d characters still due", cycles, sb.text_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // character sink: random back-pressure, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        sb.check_char(out_tdata, out_tlast);
      end
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_stall    = LONG_HOLD;
      end else if (rx_stall == 0 && idle_on && $urandom_range(0, 4) == 0) begin
        rx_stall = $urandom_range(1, 3);
      end
      if (rx_stall > 0) begin
        out_tready <= 1'b0;
        rx_stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_number(input logic [2:0] cmd, input logic [63:0] value);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    sb.note_number(cmd, value);
    numbers_sent++;
    if (cmd > itoa_pkg::FMT_HEXL64) begin
      ignored_sent++;
    end
  endtask

  // hold the input back until every character due has come out
  task automatic drain_text();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.text_q.size() != 0);
  endtask

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: v = v >> $urandom_range(0, 63);
      1: v = v & 64'hff;
      2: v = ~(v >> $urandom_range(0, 63));   // near all ones, small negatives
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] rand_cmd();
    if ($urandom_range(0, 11) == 0) begin
      return 3'($urandom_range(5, 7));
    end
    return 3'($urandom_range(0, 4));
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_number(rand_cmd(), rand_value());
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = itoa_pkg::FMT_SDEC32;
    out_tready   = 1'b0;
    idle_on      = 1'b1;
    rx_hold_req  = 1'b0;
    rx_stall     = 0;
    cycles       = 0;
    numbers_sent = 0;
    ignored_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes, every format, sign edge cases, junk in the upper word
    send_number(itoa_pkg::FMT_SDEC32, 64'd0);
    send_number(itoa_pkg::FMT_SDEC32, 64'd1);
    send_number(itoa_pkg::FMT_SDEC32, 64'h0000_0000_ffff_ffff);
    send_number(itoa_pkg::FMT_SDEC32, 64'h0000_0000_7fff_ffff);
    send_number(itoa_pkg::FMT_SDEC32, 64'h0000_0000_8000_0000);
    send_number(itoa_pkg::FMT_SDEC32, 64'hffff_ffff_0000_0005);
    send_number(itoa_pkg::FMT_SDEC32, 64'h1234_5678_ffff_fff6);
    send_number(itoa_pkg::FMT_UDEC32, 64'd0);
    send_number(itoa_pkg::FMT_UDEC32, 64'd9);
    send_number(itoa_pkg::FMT_UDEC32, 64'd1000000000);
    send_number(itoa_pkg::FMT_UDEC32, 64'hffff_ffff_ffff_ffff);
    send_number(itoa_pkg::FMT_HEXL32, 64'd0);
    send_number(itoa_pkg::FMT_HEXL32, 64'h0000_0000_dead_beef);
    send_number(itoa_pkg::FMT_HEXL32, 64'hffff_ffff_0000_0010);
    send_number(itoa_pkg::FMT_HEXU32, 64'h0000_0000_abcd_ef01);
    send_number(itoa_pkg::FMT_HEXU32, 64'h8000_0000_ffff_ffff);
    send_number(itoa_pkg::FMT_HEXL64, 64'd0);
    send_number(itoa_pkg::FMT_HEXL64, 64'hffff_ffff_ffff_ffff);
    send_number(itoa_pkg::FMT_HEXL64, 64'h0123_4567_89ab_cdef);
    send_number(itoa_pkg::FMT_HEXL64, 64'h8000_0000_0000_0000);
    send_number(3'd5, 64'h0000_0000_0000_1234);
    send_number(3'd6, 64'hffff_ffff_ffff_ffff);
    send_number(3'd7, 64'd42);
    send_number(itoa_pkg::FMT_SDEC32, 64'd10);
    drain_text();

    send_random(55);

    // sink stalls for a long stretch while numbers keep coming
    rx_hold_req = 1'b1;
    send_number(itoa_pkg::FMT_HEXL64, 64'hfedc_ba98_7654_3210);
    send_random(5);
    drain_text();

    send_random(20);

    idle_on = 1'b0;
    send_random(25);
    drain_text();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d numbers over all five formats (%0d with unused selectors),",
             numbers_sent, ignored_sent);
    $display("%0d characters checked under random and long output stalls", sb.chars_checked);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
